// ===== src/oaks_pkg.sv =====
// Shared types and constants for the open-address key set.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package oaks_pkg;

   localparam int KEY_W     = 32;
   localparam int SLOT_W    = 10;
   localparam int TS_W      = 11;
   localparam int TS_RESET  = 1024;
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = KEY_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [KEY_W-1:0] EMPTY_WORD = '0;
   localparam logic [KEY_W-1:0] TOMBSTONE  = '1;

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_FIND   = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_PROBE,
      ST_CHECK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic advance;
   } probe_ctl_type;

endpackage

`default_nettype wire

// ===== src/oaks_slot_ram.sv =====
// Single-port slot table memory with a registered read port.
// Depends on oaks_pkg for the key width.
`timescale 1ns / 1ps
`default_nettype none

module oaks_slot_ram #(
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = 10
) (
   input  wire                        clock,
   input  wire                        en,
   input  wire                        we,
   input  wire  [ADDR_W-1:0]          addr,
   input  wire  [oaks_pkg::KEY_W-1:0] wdata,
   output logic [oaks_pkg::KEY_W-1:0] rdata
);
   import oaks_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata <= mem[addr];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/oaks_mod_unit.sv =====
// Key modulo table size, restoring remainder, four key bits per cycle.
// Depends on oaks_pkg for key width and step count.
`timescale 1ns / 1ps
`default_nettype none

module oaks_mod_unit #(
   parameter int N_W = 11
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire  [oaks_pkg::KEY_W-1:0] key,
   input  wire  [N_W-1:0]             modulus,
   output logic                       done,
   output logic [N_W-1:0]             rem
);
   import oaks_pkg::*;

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [DIV_CNT_W-1:0] cnt_ff,   cnt_in;
   logic [KEY_W-1:0]     shift_ff, shift_in;
   logic [N_W-1:0]       rem_ff,   rem_in;

   always_comb begin
      logic [N_W:0]     t;
      logic [N_W-1:0]   r;
      logic [KEY_W-1:0] s;
      t        = '0;
      r        = rem_ff;
      s        = shift_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         shift_in = key;
         rem_in   = '0;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, s[KEY_W-1]};
            s = {s[KEY_W-2:0], 1'b0};
            if (t >= {1'b0, modulus}) begin
               t = t - {1'b0, modulus};
            end
            r = t[N_W-1:0];
         end
         shift_in = s;
         rem_in   = r;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

// ===== src/oaks_probe_gen.sv =====
// Quadratic probe address generator: home, +1, -1, +4, -4, ... mod n.
// Squares kept incrementally mod n; depends on oaks_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module oaks_probe_gen #(
   parameter int N_W    = 11,
   parameter int ADDR_W = 10
) (
   input  wire                          clock,
   input  wire  oaks_pkg::probe_ctl_type ctl,
   input  wire  [N_W-1:0]               modulus,
   input  wire  [N_W-1:0]               home,
   output logic [ADDR_W-1:0]            addr,
   output logic                         more
);
   import oaks_pkg::*;

   logic [N_W-1:0] m_ff,  m_in;
   logic [N_W-1:0] sq_ff, sq_in;
   logic [N_W-1:0] d_ff,  d_in;
   logic           neg_ff, neg_in;

   logic [N_W:0] sq_sum, d_sum, pos_sum, neg_dif;

   always_comb begin
      sq_sum = {1'b0, sq_ff} + {1'b0, d_ff};
      if (sq_sum >= {1'b0, modulus}) begin
         sq_sum = sq_sum - {1'b0, modulus};
      end
      d_sum = {1'b0, d_ff} + (N_W + 1)'(2);
      if (d_sum >= {1'b0, modulus}) begin
         d_sum = d_sum - {1'b0, modulus};
      end
      m_in   = m_ff;
      sq_in  = sq_ff;
      d_in   = d_ff;
      neg_in = neg_ff;
      if (ctl.start) begin
         m_in   = '0;
         sq_in  = '0;
         d_in   = N_W'(1);
         neg_in = 1'b1;
      end else if (ctl.advance) begin
         if (neg_ff) begin
            m_in   = m_ff + 1'b1;
            sq_in  = sq_sum[N_W-1:0];
            d_in   = d_sum[N_W-1:0];
            neg_in = 1'b0;
         end else begin
            neg_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      m_ff   <= m_in;
      sq_ff  <= sq_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      pos_sum = {1'b0, home} + {1'b0, sq_ff};
      if (pos_sum >= {1'b0, modulus}) begin
         pos_sum = pos_sum - {1'b0, modulus};
      end
      if (home >= sq_ff) begin
         neg_dif = {1'b0, home} - {1'b0, sq_ff};
      end else begin
         neg_dif = {1'b0, home} + {1'b0, modulus} - {1'b0, sq_ff};
      end
      addr = neg_ff ? neg_dif[ADDR_W-1:0] : pos_sum[ADDR_W-1:0];
      more = ({1'b0, m_ff} + 1'b1) < {1'b0, modulus};
   end

endmodule

`default_nettype wire

// ===== src/open_address_key_set_unit.sv =====
// Top level of the open-address key set: control sequencer, response register.
// Depends on oaks_pkg, oaks_slot_ram, oaks_mod_unit and oaks_probe_gen.
//
//   port group   direction  handshake          payload
//   req_         in         valid / stall      req_type, req_key
//   rsp_         out        valid / stall      rsp_ok, rsp_slot
//   csr_         in         valid / ready      csr_table_size
//
// Add, find, remove: accept, key mod n (4 bits a cycle), then, if n exceeds 1, a table
//   read and a check per probe, then the response is loaded.
// Clear: slots 0 to n-1, one slot written per cycle, then the response is loaded.
// After reset all CAPACITY slots are swept to zero; no request is taken meanwhile.
// A pending response does not block the next request; stall on rsp_ holds it.
`timescale 1ns / 1ps
`default_nettype none

module open_address_key_set_unit #(
   parameter int CAPACITY = 1024
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [1:0]                  req_type,
   input  wire  [oaks_pkg::KEY_W-1:0]  req_key,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_ok,
   output logic [oaks_pkg::SLOT_W-1:0] rsp_slot,
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire  [oaks_pkg::TS_W-1:0]   csr_table_size
);
   import oaks_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int N_W   = $clog2(CAPACITY + 1);
   localparam int CMP_W = (N_W > TS_W) ? N_W : TS_W;

   state_type            state_ff, state_in;
   req_kind_type         kind_ff;
   logic [KEY_W-1:0]     key_ff;
   logic [N_W-1:0]       n_ff;
   logic [IDX_W-1:0]     addr_ff;
   logic [IDX_W-1:0]     clr_ff;
   logic [IDX_W-1:0]     clr_last_ff;
   logic                 clr_rsp_ff;
   logic                 res_ok_ff;
   logic [IDX_W-1:0]     res_slot_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_ok_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic [TS_W-1:0]      ts_ff;

   logic                 req_fire, rsp_free;
   logic [CMP_W-1:0]     ts_ext, n_cmp;
   logic [N_W-1:0]       n_eff, n_less1;
   logic                 is_add, hit, stop;
   logic                 ram_en, ram_we;
   logic [IDX_W-1:0]     ram_addr;
   logic [KEY_W-1:0]     ram_wdata, ram_rdata;
   logic                 mod_start, mod_done;
   logic [N_W-1:0]       home;
   probe_ctl_type        probe_ctl;
   logic [IDX_W-1:0]     probe_addr;
   logic                 probe_more;
   logic [SLOT_W+IDX_W-1:0] slot_wide;

   oaks_slot_ram #(.DEPTH(CAPACITY), .ADDR_W(IDX_W)) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   oaks_mod_unit #(.N_W(N_W)) u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .key     (req_key),
      .modulus (n_ff),
      .done    (mod_done),
      .rem     (home)
   );

   oaks_probe_gen #(.N_W(N_W), .ADDR_W(IDX_W)) u_probe (
      .clock   (clock),
      .ctl     (probe_ctl),
      .modulus (n_ff),
      .home    (home),
      .addr    (probe_addr),
      .more    (probe_more)
   );

   always_comb begin
      ts_ext = CMP_W'(ts_ff);
      if (ts_ext == '0) begin
         n_cmp = CMP_W'(1);
      end else if (ts_ext > CMP_W'(CAPACITY)) begin
         n_cmp = CMP_W'(CAPACITY);
      end else begin
         n_cmp = ts_ext;
      end
      n_eff   = n_cmp[N_W-1:0];
      n_less1 = n_eff - 1'b1;
   end

   assign req_fire = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign is_add   = (kind_ff == REQ_ADD);

   always_comb begin
      if (is_add) begin
         hit = (ram_rdata == EMPTY_WORD) || (ram_rdata == TOMBSTONE) || (ram_rdata == key_ff);
      end else begin
         hit = (ram_rdata != EMPTY_WORD) && (ram_rdata == key_ff);
      end
      stop = !is_add && (ram_rdata == EMPTY_WORD);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == clr_last_ff) begin
               state_in = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_kind_type'(req_type) == REQ_CLEAR) ? ST_CLEAR : ST_DIV;
            end
         end
         ST_DIV: begin
            if (mod_done) begin
               state_in = (n_ff > N_W'(1)) ? ST_PROBE : ST_DONE;
            end
         end
         ST_PROBE: state_in = ST_CHECK;
         ST_CHECK: begin
            if (hit || stop || !probe_more) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_PROBE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall         = 1'b1;
      ram_en            = 1'b0;
      ram_we            = 1'b0;
      ram_addr          = addr_ff;
      ram_wdata         = EMPTY_WORD;
      mod_start         = 1'b0;
      probe_ctl.start   = 1'b0;
      probe_ctl.advance = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = clr_ff;
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            mod_start = req_fire && (req_kind_type'(req_type) != REQ_CLEAR);
         end
         ST_DIV: begin
            probe_ctl.start = mod_done;
         end
         ST_PROBE: begin
            ram_en   = 1'b1;
            ram_addr = probe_addr;
         end
         ST_CHECK: begin
            ram_en            = hit && (kind_ff != REQ_FIND);
            ram_we            = ram_en;
            ram_wdata         = is_add ? key_ff : TOMBSTONE;
            probe_ctl.advance = !(hit || stop || !probe_more);
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         clr_last_ff  <= IDX_W'(CAPACITY - 1);
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ts_ff        <= TS_W'(TS_RESET);
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            ts_ff <= csr_table_size;
         end
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (req_fire) begin
            clr_ff      <= '0;
            clr_last_ff <= n_less1[IDX_W-1:0];
            clr_rsp_ff  <= 1'b1;
         end
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         kind_ff <= req_kind_type'(req_type);
         key_ff  <= req_key;
         n_ff    <= n_eff;
      end
      if (state_ff == ST_PROBE) begin
         addr_ff <= probe_addr;
      end
      case (state_ff)
         ST_CLEAR: begin
            res_ok_ff   <= 1'b1;
            res_slot_ff <= '0;
         end
         ST_DIV: begin
            res_ok_ff   <= 1'b0;
            res_slot_ff <= '0;
         end
         ST_CHECK: begin
            res_ok_ff   <= hit;
            res_slot_ff <= hit ? addr_ff : '0;
         end
         default: begin
         end
      endcase
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_ok_ff   <= res_ok_ff;
         rsp_slot_ff <= slot_wide[SLOT_W-1:0];
      end
   end

   assign slot_wide = {{SLOT_W{1'b0}}, res_slot_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok    = rsp_ok_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign csr_ready = 1'b1;

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ST_CHECK || state_ff == ST_CLEAR))
      else $error("slot table written outside check or clear");

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> N_W'(addr_ff) < n_ff)
      else $error("probed slot outside active table");

   a_mod_done_in_div: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> state_ff == ST_DIV)
      else $error("modulo result arrived outside division state");

   a_fail_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> rsp_slot_ff == '0)
      else $error("failed request reports a non-zero slot");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for open_address_key_set_unit: directed and random add, find,
// remove and clear requests over many table sizes, checked against an in-bench model.
// Depends on oaks_pkg and the open_address_key_set_unit RTL only.
`timescale 1ns / 1ps

module testbench;
   import oaks_pkg::*;

   localparam int CAPACITY       = 1024;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      logic              ok;
      logic [SLOT_W-1:0] slot;
   } slot_reply_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type = REQ_ADD;
   logic [KEY_W-1:0]  req_key = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_ok;
   logic [SLOT_W-1:0] rsp_slot;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [TS_W-1:0]   csr_table_size = '0;

   logic [KEY_W-1:0]  stored_keys [0:CAPACITY-1];
   logic [TS_W-1:0]   table_size_setting = TS_W'(TS_RESET);
   slot_reply_type    pending_replies [$];

   bit steady_traffic = 1'b0;
   int mismatch_count = 0;
   int responses_checked = 0;
   int sizes_tried = 0;
   int kind_count [4] = '{0, 0, 0, 0};

   open_address_key_set_unit #(.CAPACITY(CAPACITY)) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_slot       (rsp_slot),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_table_size (csr_table_size)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         stored_keys[i] = EMPTY_WORD;
      end
   end

   function automatic int effective_slots(logic [TS_W-1:0] size);
      if (size == 0) return 1;
      if (size > CAPACITY) return CAPACITY;
      return int'(size);
   endfunction

   function automatic int wrap_index(longint home, longint offset, int n);
      longint pos;
      pos = (home + offset) % n;
      if (pos < 0) pos += n;
      return int'(pos);
   endfunction

   // 1: hit, -1: stop with failure, 0: keep probing
   function automatic int test_entry(int idx, logic [KEY_W-1:0] key, bit claim);
      logic [KEY_W-1:0] word;
      word = stored_keys[idx];
      if (claim) return (word == EMPTY_WORD || word == TOMBSTONE || word == key) ? 1 : 0;
      if (word == EMPTY_WORD) return -1;
      return (word == key) ? 1 : 0;
   endfunction

   function automatic int locate_slot(logic [KEY_W-1:0] key, bit claim, int n);
      longint home;
      longint square;
      int idx;
      int verdict;
      home = longint'({32'd0, key}) % n;
      if (n <= 1) return -1;
      verdict = test_entry(int'(home), key, claim);
      if (verdict != 0) return (verdict > 0) ? int'(home) : -1;
      for (int m = 1; m < n; m++) begin
         square = longint'(m) * m;
         idx = wrap_index(home, square, n);
         verdict = test_entry(idx, key, claim);
         if (verdict != 0) return (verdict > 0) ? idx : -1;
         if (m + 1 >= n) return -1;
         idx = wrap_index(home, -square, n);
         verdict = test_entry(idx, key, claim);
         if (verdict != 0) return (verdict > 0) ? idx : -1;
      end
      return -1;
   endfunction

   function automatic slot_reply_type apply_request(req_kind_type kind, logic [KEY_W-1:0] key);
      slot_reply_type reply;
      int n;
      int hit;
      reply = '0;
      n = effective_slots(table_size_setting);
      if (kind == REQ_CLEAR) begin
         for (int i = 0; i < n; i++) begin
            stored_keys[i] = EMPTY_WORD;
         end
         reply.ok = 1'b1;
      end else begin
         hit = locate_slot(key, kind == REQ_ADD, n);
         if (hit >= 0) begin
            if (kind == REQ_ADD) begin
               stored_keys[hit] = key;
            end else if (kind == REQ_REMOVE) begin
               stored_keys[hit] = TOMBSTONE;
            end
            reply.ok   = 1'b1;
            reply.slot = SLOT_W'(hit);
         end
      end
      return reply;
   endfunction

   function automatic void report_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, what);
      end
   endfunction

   always @(posedge clock) begin
      slot_reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_replies.size() == 0) begin
            report_failure($sformatf("response with nothing pending: ok=%0b slot=%0d",
                                     rsp_ok, rsp_slot));
         end else begin
            want = pending_replies.pop_front();
            responses_checked++;
            if (rsp_ok !== want.ok || rsp_slot !== want.slot) begin
               report_failure($sformatf("response %0d: expected ok=%0b slot=%0d, got ok=%0b slot=%0d",
                                        responses_checked, want.ok, want.slot, rsp_ok, rsp_slot));
            end
         end
      end
   end

   initial begin : rsp_back_pressure
      forever begin
         @(posedge clock);
         if (!steady_traffic && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: %0d cycles without a handshake, %0d responses pending",
               quiet_cycles, pending_replies.size());
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_request(req_kind_type kind, logic [KEY_W-1:0] key);
      if (!steady_traffic && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= kind;
      req_key   <= key;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_replies.push_back(apply_request(kind, key));
      kind_count[kind]++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Follow every call with at least one request before the next one.
   task automatic set_table_size(logic [TS_W-1:0] value);
      wait_for_drain();
      csr_valid      <= 1'b1;
      csr_table_size <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      csr_valid <= 1'b0;
      table_size_setting = value;
      sizes_tried++;
   endtask

   task automatic run_random_traffic(int count);
      logic [KEY_W-1:0] key_pool [0:63];
      logic [KEY_W-1:0] key;
      req_kind_type kind;
      int n;
      int pool_used;
      int base_home;
      int roll;
      n = effective_slots(table_size_setting);
      pool_used = (2 * n + 2 < 64) ? 2 * n + 2 : 64;
      base_home = $urandom_range(0, n - 1);
      for (int i = 0; i < 64; i++) begin
         if (i % 2 == 0) begin
            key_pool[i] = KEY_W'((base_home + i % 8) % n)
                        + KEY_W'(n) * KEY_W'($urandom_range(0, 4194303));
         end else begin
            key_pool[i] = $urandom;
         end
      end
      for (int i = 0; i < count; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 3) begin
            kind = REQ_CLEAR;
         end else if (roll < 45) begin
            kind = REQ_ADD;
         end else if (roll < 72) begin
            kind = REQ_FIND;
         end else begin
            kind = REQ_REMOVE;
         end
         roll = $urandom_range(0, 19);
         if (roll == 0) begin
            key = $urandom_range(0, 1) ? TOMBSTONE : EMPTY_WORD;
         end else if (roll < 3) begin
            key = $urandom;
         end else begin
            key = key_pool[$urandom_range(0, pool_used - 1)];
         end
         send_request(kind, key);
      end
   endtask

   task automatic test_basic_operations();
      send_request(REQ_ADD, 32'd5);
      send_request(REQ_ADD, 32'd5);
      send_request(REQ_ADD, 32'd1029);
      send_request(REQ_FIND, 32'd1029);
      send_request(REQ_ADD, 32'd3077);
      send_request(REQ_FIND, EMPTY_WORD);
      send_request(REQ_ADD, EMPTY_WORD);
      send_request(REQ_ADD, TOMBSTONE);
      send_request(REQ_FIND, TOMBSTONE);
      send_request(REQ_REMOVE, TOMBSTONE);
      send_request(REQ_REMOVE, 32'd5);
      send_request(REQ_FIND, 32'd1029);
      send_request(REQ_ADD, 32'd2053);
      send_request(REQ_REMOVE, 32'd12345);
      send_request(REQ_FIND, 32'hFFFF_FFFE);
      send_request(REQ_CLEAR, 32'hA5A5_5A5A);
      send_request(REQ_FIND, 32'd1029);
      set_table_size(TS_W'(2));
      send_request(REQ_ADD, 32'd4);
      send_request(REQ_ADD, 32'd7);
      send_request(REQ_ADD, 32'd9);
      send_request(REQ_FIND, 32'd9);
      send_request(REQ_REMOVE, 32'd7);
      set_table_size(TS_W'(1));
      send_request(REQ_ADD, 32'd3);
      send_request(REQ_FIND, 32'd3);
      send_request(REQ_CLEAR, 32'd0);
   endtask

   task automatic test_small_tables();
      for (int phase = 0; phase < 6; phase++) begin
         set_table_size(TS_W'($urandom_range(2, 16)));
         run_random_traffic(150);
      end
   endtask

   task automatic test_wide_tables();
      for (int phase = 0; phase < 3; phase++) begin
         set_table_size(TS_W'($urandom_range(17, 128)));
         run_random_traffic(140);
      end
      set_table_size(TS_W'(CAPACITY));
      run_random_traffic(40);
   endtask

   task automatic test_size_extremes();
      logic [TS_W-1:0] corner_sizes [7] = '{0, 1, 2047, 1025, 2, 3, 1024};
      foreach (corner_sizes[i]) begin
         set_table_size(corner_sizes[i]);
         run_random_traffic(25);
      end
      set_table_size(TS_W'($urandom_range(0, 2047)));
      run_random_traffic(20);
   endtask

   task automatic test_drain_pauses();
      set_table_size(TS_W'($urandom_range(4, 32)));
      for (int round = 0; round < 5; round++) begin
         run_random_traffic(40);
         wait_for_drain();
      end
   endtask

   task automatic test_steady_stream();
      steady_traffic = 1'b1;
      set_table_size(TS_W'($urandom_range(5, 40)));
      run_random_traffic(250);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_operations();
      test_small_tables();
      test_wide_tables();
      test_size_extremes();
      test_drain_pauses();
      test_steady_stream();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d requests: %0d add, %0d find, %0d remove, %0d clear over %0d sizes",
               kind_count[REQ_ADD] + kind_count[REQ_FIND] + kind_count[REQ_REMOVE]
               + kind_count[REQ_CLEAR], kind_count[REQ_ADD], kind_count[REQ_FIND],
               kind_count[REQ_REMOVE], kind_count[REQ_CLEAR], sizes_tried);
      $display("Checked %0d responses, %0d mismatches", responses_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== open_address_key_set_unit.f =====
src/oaks_pkg.sv
src/oaks_slot_ram.sv
src/oaks_mod_unit.sv
src/oaks_probe_gen.sv
src/open_address_key_set_unit.sv
bench/testbench.sv
